// ===== rtl/bept_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block execution profile table: shared definitions
// Sizes, register indexes, lookup status codes and the row layouts of the
// key and counter memories.
// ----------------------------------------------------------------------------
package bept_pkg;

  // Slot count must be a power of two: the start slot is the low hash bits.
  localparam int unsigned TABLE_SLOTS = 4096;
  localparam int unsigned EXIT_WAYS   = 4;
  localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W       = 64;

  localparam logic [63:0] HASH_GOLDEN = 64'h9e37_79b9_7f4a_7c15;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 63;
  localparam logic [CFG_IDX_W-1:0]  REG_ENABLE          = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_REPORT_INTERVAL = 1'd1;
  localparam logic [CFG_DATA_W-1:0] INTERVAL_RESET      = 63'd10000;

  typedef enum logic [1:0] {
    STAT_HIT  = 2'd0,
    STAT_NEW  = 2'd1,
    STAT_DROP = 2'd2,
    STAT_OFF  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_LOOKUP,
    ST_CHECK,
    ST_UPDATE,
    ST_RESULT
  } state_e;

  // Key memory row; valid shares the row so the clearing pass resets it.
  typedef struct packed {
    logic        valid;
    logic [63:0] pc;
    logic [63:0] seg;
    logic [63:0] pair;
    logic [31:0] sizes;
  } key_row_t;

  // Counter memory row: slot executions plus one counter per exit.
  typedef struct packed {
    logic [CNT_W-1:0]                execs;
    logic [EXIT_WAYS-1:0][CNT_W-1:0] exits;
  } cnt_row_t;

  typedef struct packed {
    logic [63:0] pc;
    logic [63:0] seg;
    logic [63:0] pair;
    logic [31:0] sizes;
    logic [63:0] host;
    logic [3:0]  exit_code;
  } item_t;

  // Requests from the lookup controller to the statistics unit
  typedef struct packed {
    logic count_exec;
    logic claim;
    logic drop;
    logic check_report;
  } stats_cmd_t;

  typedef struct packed {
    logic             enable;
    logic [CNT_W-1:0] exec_total;
    logic [SLOT_W:0]  claimed;
    logic [CNT_W-1:0] dropped;
    logic             report_due;
  } stats_t;

  typedef struct packed {
    status_e          status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0] execs;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] total;
    logic [SLOT_W:0]  unique_cnt;
    logic [CNT_W-1:0] dropped;
    logic             due;
  } result_t;

endpackage

// ===== rtl/bept_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block execution profile table: channel interfaces
// Valid/ready channels for executed-block reports and lookup results.
// ----------------------------------------------------------------------------
interface bept_in_if import bept_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [63:0]       block_pc;
  logic [63:0]       seg_base;
  logic [31:0]       mode_flags;
  logic [31:0]       compile_flags;
  logic [15:0]       block_bytes;
  logic [15:0]       insn_count;
  logic [63:0]       host_code_addr;
  logic signed [3:0] exit_code;

  modport source (
    output valid, block_pc, seg_base, mode_flags, compile_flags, block_bytes,
           insn_count, host_code_addr, exit_code,
    input  ready
  );
  modport sink (
    input  valid, block_pc, seg_base, mode_flags, compile_flags, block_bytes,
           insn_count, host_code_addr, exit_code,
    output ready
  );
endinterface

interface bept_out_if import bept_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        lookup_status;
  logic [SLOT_W-1:0] slot_index;
  logic [CNT_W-1:0]  block_execs;
  logic [CNT_W-1:0]  exit_hits;
  logic [CNT_W-1:0]  total_execs;
  logic [SLOT_W:0]   unique_blocks;
  logic [CNT_W-1:0]  dropped_blocks;
  logic              report_due;

  modport source (
    output valid, lookup_status, slot_index, block_execs, exit_hits, total_execs,
           unique_blocks, dropped_blocks, report_due,
    input  ready
  );
  modport sink (
    input  valid, lookup_status, slot_index, block_execs, exit_hits, total_execs,
           unique_blocks, dropped_blocks, report_due,
    output ready
  );
endinterface

// ===== rtl/bept_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block execution profile table: generic RAM
// One write port, one read port, read data registered.
module bept_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bept_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block execution profile table: statistics unit
// Configuration registers, running totals and the report threshold.
// ----------------------------------------------------------------------------
module bept_stats import bept_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  stats_cmd_t            cmd_i,
  output stats_t                stats_o
);

  logic                  enable_q;
  logic [CFG_DATA_W-1:0] interval_q;
  logic [CNT_W-1:0]      exec_total_q;
  logic [SLOT_W:0]       claimed_q;
  logic [CNT_W-1:0]      dropped_q;
  logic [CNT_W-1:0]      next_thr_q;
  logic                  due;

  // exec_total already holds this item's count when the check is made
  assign due = cmd_i.check_report && (exec_total_q >= next_thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      interval_q   <= INTERVAL_RESET;
      exec_total_q <= '0;
      claimed_q    <= '0;
      dropped_q    <= '0;
      next_thr_q   <= CNT_W'(INTERVAL_RESET);
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ENABLE: begin
            enable_q <= cfg_data_i[0];
          end
          REG_REPORT_INTERVAL: begin
            interval_q <= cfg_data_i;
            next_thr_q <= exec_total_q + CNT_W'(cfg_data_i);
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.count_exec) begin
        exec_total_q <= exec_total_q + 1'b1;
      end
      if (cmd_i.claim) begin
        claimed_q <= claimed_q + 1'b1;
      end
      if (cmd_i.drop) begin
        dropped_q <= dropped_q + 1'b1;
      end
      if (due) begin
        next_thr_q <= exec_total_q + CNT_W'(interval_q);
      end
    end
  end

  assign stats_o.enable     = enable_q;
  assign stats_o.exec_total = exec_total_q;
  assign stats_o.claimed    = claimed_q;
  assign stats_o.dropped    = dropped_q;
  assign stats_o.report_due = due;

endmodule

// ===== rtl/block_exec_profile_table.sv =====
`timescale 1ns / 1ps
// Lookup: the probe walk visits 1 to TABLE_SLOTS slots; a disabled item
//   skips the probe and goes from the hash state to the result.
// Intake: a new item is taken only in the idle state, after the last result
//   is registered; the key memory is read one slot per cycle during the walk.
// Reset: a clearing pass over all TABLE_SLOTS (4096) slots resets the slot valid
//   bits; input ready stays low until it ends. Configuration is taken at once.
// ----------------------------------------------------------------------------
// Block execution profile table
// Hashed, linearly probed table of executed code blocks with per-slot and
// per-exit execution counters, running totals and an interval report flag.
// ----------------------------------------------------------------------------
module block_exec_profile_table import bept_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bept_in_if.sink               in_i,
  bept_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] clr_q;
  logic              out_valid_q;
  logic              out_free;

  item_t             item_q;
  logic [SLOT_W-1:0] idx_q;
  logic [SLOT_W-1:0] probe_q;
  status_e           status_q;
  logic [CNT_W-1:0]  execs_q;
  logic [CNT_W-1:0]  hits_q;
  logic              due_q;
  result_t           out_q;

  logic              key_we;
  logic [SLOT_W-1:0] key_waddr;
  key_row_t          key_wdata;
  logic [SLOT_W-1:0] key_raddr;
  key_row_t          key_rdata;
  logic              cnt_we;
  cnt_row_t          cnt_wdata;
  cnt_row_t          cnt_rdata;

  stats_cmd_t        stats_cmd;
  stats_t            stats;

  logic [63:0]       h_mix;
  logic [63:0]       h_full;
  logic              key_match;
  logic              probe_last;
  logic              exit_counted;
  cnt_row_t          cnt_base;
  logic [CNT_W-1:0]  exec_new;
  logic [CNT_W-1:0]  hit_sel;
  logic [CNT_W-1:0]  hit_new;

  assign out_free = !out_valid_q || out_o.ready;

  // Start slot hash
  always_comb begin
    h_mix  = item_q.pc ^ (item_q.seg + HASH_GOLDEN + (item_q.pc << 6) + (item_q.pc >> 2));
    h_full = h_mix ^ item_q.pair ^ (item_q.host >> 4);
  end

  assign key_match  = (key_rdata.pc == item_q.pc) && (key_rdata.seg == item_q.seg) &&
                      (key_rdata.pair == item_q.pair) && (key_rdata.sizes == item_q.sizes);
  assign probe_last = (probe_q == SLOT_W'(TABLE_SLOTS - 1));

  assign exit_counted = !item_q.exit_code[3] && (int'(item_q.exit_code[2:0]) < EXIT_WAYS);

  // Counter read-modify-write; a claimed slot starts from zero
  always_comb begin
    cnt_base = (status_q == STAT_NEW) ? '0 : cnt_rdata;
    exec_new = cnt_base.execs + 1'b1;
    hit_sel  = '0;
    for (int w = 0; w < EXIT_WAYS; w++) begin
      if (item_q.exit_code[2:0] == 3'(w)) begin
        hit_sel = cnt_base.exits[w];
      end
    end
    hit_new         = hit_sel + 1'b1;
    cnt_wdata       = cnt_base;
    cnt_wdata.execs = exec_new;
    for (int w = 0; w < EXIT_WAYS; w++) begin
      if (exit_counted && (item_q.exit_code[2:0] == 3'(w))) begin
        cnt_wdata.exits[w] = hit_new;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == SLOT_W'(TABLE_SLOTS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_i.valid) state_d = ST_HASH;
      end
      ST_HASH: begin
        state_d = stats.enable ? ST_LOOKUP : ST_RESULT;
      end
      ST_LOOKUP: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!key_rdata.valid || key_match || probe_last) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memory and statistics controls
  always_comb begin
    in_i.ready   = 1'b0;
    key_we       = 1'b0;
    key_waddr    = idx_q;
    key_wdata    = '0;
    key_raddr    = idx_q;
    cnt_we       = 1'b0;
    stats_cmd    = '0;
    case (state_q)
      ST_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr_q;
      end
      ST_IDLE: begin
        in_i.ready = 1'b1;
      end
      ST_HASH: begin
        stats_cmd.count_exec = stats.enable;
      end
      ST_CHECK: begin
        // Fetch the next slot while this one is being compared
        key_raddr = idx_q + 1'b1;
        if (!key_rdata.valid) begin
          key_we    = 1'b1;
          key_wdata = '{valid: 1'b1, pc: item_q.pc, seg: item_q.seg,
                        pair: item_q.pair, sizes: item_q.sizes};
        end
      end
      ST_UPDATE: begin
        cnt_we                 = (status_q != STAT_DROP);
        stats_cmd.claim        = (status_q == STAT_NEW);
        stats_cmd.drop         = (status_q == STAT_DROP);
        stats_cmd.check_report = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          item_q.pc        <= in_i.block_pc;
          item_q.seg       <= in_i.seg_base;
          item_q.pair      <= {in_i.mode_flags, in_i.compile_flags};
          item_q.sizes     <= {in_i.block_bytes, in_i.insn_count};
          item_q.host      <= in_i.host_code_addr;
          item_q.exit_code <= in_i.exit_code;
        end
      end
      ST_HASH: begin
        idx_q    <= h_full[SLOT_W-1:0];
        probe_q  <= '0;
        status_q <= STAT_OFF;
        execs_q  <= '0;
        hits_q   <= '0;
        due_q    <= 1'b0;
      end
      ST_CHECK: begin
        if (!key_rdata.valid) begin
          status_q <= STAT_NEW;
        end else if (key_match) begin
          status_q <= STAT_HIT;
        end else if (probe_last) begin
          status_q <= STAT_DROP;
        end else begin
          idx_q   <= idx_q + 1'b1;
          probe_q <= probe_q + 1'b1;
        end
      end
      ST_UPDATE: begin
        execs_q <= (status_q == STAT_DROP) ? '0 : exec_new;
        hits_q  <= (status_q != STAT_DROP && exit_counted) ? hit_new : '0;
        due_q   <= stats.report_due;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_q.status     <= status_q;
          out_q.slot       <= (status_q == STAT_HIT || status_q == STAT_NEW) ? idx_q : '0;
          out_q.execs      <= execs_q;
          out_q.hits       <= hits_q;
          out_q.total      <= stats.exec_total;
          out_q.unique_cnt <= stats.claimed;
          out_q.dropped    <= stats.dropped;
          out_q.due        <= due_q;
        end
      end
      default: begin
      end
    endcase
  end

  bept_ram #(
    .WIDTH ($bits(key_row_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  bept_ram #(
    .WIDTH ($bits(cnt_row_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (idx_q),
    .wdata_i (cnt_wdata),
    .raddr_i (idx_q),
    .rdata_o (cnt_rdata)
  );

  bept_stats u_stats (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (stats_cmd),
    .stats_o    (stats)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.lookup_status  = out_q.status;
  assign out_o.slot_index     = out_q.slot;
  assign out_o.block_execs    = out_q.execs;
  assign out_o.exit_hits      = out_q.hits;
  assign out_o.total_execs    = out_q.total;
  assign out_o.unique_blocks  = out_q.unique_cnt;
  assign out_o.dropped_blocks = out_q.dropped;
  assign out_o.report_due     = out_q.due;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |-> (state_q == ST_CLEAR || state_q == ST_CHECK))
    else $error("key memory written outside clear or probe");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |-> (state_q == ST_UPDATE && status_q != STAT_DROP))
    else $error("counter row written for a dropped or idle lookup");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESULT))
    else $error("result raised without a finished lookup");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && key_rdata.valid && !key_match && !probe_last)
      |=> (idx_q == $past(idx_q) + 1'b1))
    else $error("probe walk did not advance by one slot");

endmodule
